### hw/rtl/sob_pkg.sv
// Shared types, constants and helpers for the sub-octave bass generator.
// Used by sob_cfg, sob_ctrl, sob_dp and the top level; depends on nothing.
package sob_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Fixed-point formats: states are Q4.27, coefficients Q0.16.
  localparam int Q_FRAC       = 27;
  localparam int COEF_SHIFT   = 16;
  localparam int AMOUNT_SHIFT = 11;
  localparam int X_W          = 28;           // mono detector input
  localparam int A_W          = 34;           // multiplier operand A
  localparam int B_W          = 33;           // multiplier operand B
  localparam int P_W          = A_W + B_W;    // product

  localparam logic [16:0]        AMOUNT_ONE   = 17'd65536;
  localparam logic signed [31:0] BYPASS_LIMIT = 32'sd13421;
  localparam logic signed [B_W-1:0] GAIN_2P2  = 33'sd144179;

  typedef enum logic [2:0] {
    REG_TARGET_AMOUNT      = 3'd0,
    REG_AMOUNT_SMOOTH_COEF = 3'd1,
    REG_BAND_LOWPASS_COEF  = 3'd2,
    REG_BAND_HIGHPASS_COEF = 3'd3,
    REG_SUB_LOWPASS_COEF   = 3'd4,
    REG_ATTACK_COEF        = 3'd5,
    REG_RELEASE_COEF       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [16:0] target_amount;
    logic [15:0] amount_smooth_coef;
    logic [15:0] band_lowpass_coef;
    logic [15:0] band_highpass_coef;
    logic [15:0] sub_lowpass_coef;
    logic [15:0] attack_coef;
    logic [15:0] release_coef;
  } cfg_t;

  localparam logic [16:0] RST_TARGET_AMOUNT      = 17'd0;
  localparam logic [15:0] RST_AMOUNT_SMOOTH_COEF = 16'd68;
  localparam logic [15:0] RST_BAND_LOWPASS_COEF  = 16'd1693;
  localparam logic [15:0] RST_BAND_HIGHPASS_COEF = 16'd300;
  localparam logic [15:0] RST_SUB_LOWPASS_COEF   = 16'd767;
  localparam logic [15:0] RST_ATTACK_COEF        = 16'd340;
  localparam logic [15:0] RST_RELEASE_COEF       = 16'd17;

  // Operations of the shared multiplier, in the order they run.
  typedef enum logic [2:0] {
    OP_AMOUNT = 3'd0,
    OP_LOW1   = 3'd1,
    OP_LOW2   = 3'd2,
    OP_HIGH   = 3'd3,
    OP_ENV    = 3'd4,
    OP_GAIN   = 3'd5,
    OP_SUB    = 3'd6,
    OP_MIX    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MUL  = 3'd1,
    ST_WB   = 3'd2,
    ST_BAND = 3'd3,
    ST_OUT  = 3'd4
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic wb;
    logic band;
    logic out_load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

### hw/rtl/sub_octave_bass_generator.sv
// Top level of the sub-octave bass generator: register file, sequencer and
// datapath. Depends on sob_pkg, sob_cfg, sob_ctrl and sob_dp.
//
//   Channel   Ports                                   Moves
//   input     in_valid, in_stall, in_left_in/right_in  one stereo sample pair
//   output    out_valid, out_stall, out_left_out/...   one processed pair
//   config    psel, penable, pwrite, paddr, pwdata...  one register write/read
//
// Every filter update of a sample is a multiply state (ST_MUL) and a
// write-back state (ST_WB) on the one shared multiplier. A bypassed sample
// goes from the load straight to the output state (ST_OUT).
// A new sample is taken in the cycle after its predecessor enters the output
// register, even while that result still waits on out_stall.
// Reset is synchronous; it restores the register defaults and clears all
// filter state, with no clearing pass.
module sub_octave_bass_generator #(
  parameter int SAMPLE_BITS    = 24,
  parameter int SUB_POLE_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]  in_right_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_left_out,
  output logic signed [SAMPLE_BITS-1:0]  out_right_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sob_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sob_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sob_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sob_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  sob_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sob_ctrl #(
    .SUB_POLE_COUNT (SUB_POLE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sob_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .SUB_POLE_COUNT (SUB_POLE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule

### hw/rtl/sob_cfg.sv
// Configuration register file on an APB-style port.
// Depends on sob_pkg for the register map, reset values and cfg_t.
module sob_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sob_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sob_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sob_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output sob_pkg::cfg_t                      cfg
);
  import sob_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_amount      <= RST_TARGET_AMOUNT;
      cfg_r.amount_smooth_coef <= RST_AMOUNT_SMOOTH_COEF;
      cfg_r.band_lowpass_coef  <= RST_BAND_LOWPASS_COEF;
      cfg_r.band_highpass_coef <= RST_BAND_HIGHPASS_COEF;
      cfg_r.sub_lowpass_coef   <= RST_SUB_LOWPASS_COEF;
      cfg_r.attack_coef        <= RST_ATTACK_COEF;
      cfg_r.release_coef       <= RST_RELEASE_COEF;
    end else if (wr_en) begin
      case (idx)
        REG_TARGET_AMOUNT:      cfg_r.target_amount      <= pwdata[16:0];
        REG_AMOUNT_SMOOTH_COEF: cfg_r.amount_smooth_coef <= pwdata[15:0];
        REG_BAND_LOWPASS_COEF:  cfg_r.band_lowpass_coef  <= pwdata[15:0];
        REG_BAND_HIGHPASS_COEF: cfg_r.band_highpass_coef <= pwdata[15:0];
        REG_SUB_LOWPASS_COEF:   cfg_r.sub_lowpass_coef   <= pwdata[15:0];
        REG_ATTACK_COEF:        cfg_r.attack_coef        <= pwdata[15:0];
        REG_RELEASE_COEF:       cfg_r.release_coef       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_AMOUNT:      prdata = CFG_DATA_W'(cfg_r.target_amount);
      REG_AMOUNT_SMOOTH_COEF: prdata = CFG_DATA_W'(cfg_r.amount_smooth_coef);
      REG_BAND_LOWPASS_COEF:  prdata = CFG_DATA_W'(cfg_r.band_lowpass_coef);
      REG_BAND_HIGHPASS_COEF: prdata = CFG_DATA_W'(cfg_r.band_highpass_coef);
      REG_SUB_LOWPASS_COEF:   prdata = CFG_DATA_W'(cfg_r.sub_lowpass_coef);
      REG_ATTACK_COEF:        prdata = CFG_DATA_W'(cfg_r.attack_coef);
      REG_RELEASE_COEF:       prdata = CFG_DATA_W'(cfg_r.release_coef);
      default:                prdata = '0;
    endcase
  end

endmodule

### hw/rtl/sob_ctrl.sv
// Sequencer for the sub-octave generator: handshakes and the operation order
// of the shared multiplier. Depends on sob_pkg; drives sob_dp by dp_cmd_t.
module sob_ctrl #(
  parameter int SUB_POLE_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sob_pkg::dp_status_t status,
  output sob_pkg::dp_cmd_t    cmd
);
  import sob_pkg::*;

  localparam int K_W = SUB_POLE_COUNT > 1 ? $clog2(SUB_POLE_COUNT) : 1;
  localparam logic [K_W-1:0] K_LAST = K_W'(SUB_POLE_COUNT - 1);

  state_t         state_r, state_nxt;
  op_t            op_r, op_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_AMOUNT;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.bypass) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_MUL;
            op_nxt    = OP_AMOUNT;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = ST_MUL;
        case (op_r)
          OP_AMOUNT: op_nxt = OP_LOW1;
          OP_LOW1:   op_nxt = OP_LOW2;
          OP_LOW2:   op_nxt = OP_HIGH;
          OP_HIGH: begin
            state_nxt = ST_BAND;
            op_nxt    = OP_ENV;
          end
          OP_ENV:    op_nxt = OP_GAIN;
          OP_GAIN: begin
            op_nxt = OP_SUB;
            k_nxt  = '0;
          end
          OP_SUB: begin
            if (k_r == K_LAST) begin
              op_nxt = OP_MIX;
            end else begin
              k_nxt = K_W'(k_r + 1'b1);
            end
          end
          OP_MIX:    state_nxt = ST_OUT;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_BAND: begin
        cmd.band  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_OUT: begin
        // The finished sample waits here until the output register is free.
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but next transfer not blocked");

  a_chain_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && op_r == OP_SUB && k_r == K_LAST)
      |=> (state_r == ST_MUL && op_r == OP_MIX))
    else $error("last sub pole not followed by the mix multiply");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && out_stall)
      |=> (state_r == ST_OUT && out_valid_r))
    else $error("pending result overwritten");
`endif

endmodule

### hw/rtl/sob_dp.sv
// Datapath of the sub-octave generator: filter states, one shared signed
// multiplier with write-back logic, and the output register. Uses sob_pkg.
module sob_dp #(
  parameter int SAMPLE_BITS    = 24,
  parameter int SUB_POLE_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sob_pkg::cfg_t                 cfg,
  input  sob_pkg::dp_cmd_t              cmd,
  output sob_pkg::dp_status_t           status,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out
);
  import sob_pkg::*;

  localparam int LSH    = (28 - SAMPLE_BITS) > 0 ? 28 - SAMPLE_BITS : 0;
  localparam int RSH    = SAMPLE_BITS > 28 ? SAMPLE_BITS - 28 : 0;
  localparam int XS_W   = SAMPLE_BITS + 1 + LSH;
  localparam int MIX_SH = Q_FRAC + LSH;
  localparam int SUB_W  = SAMPLE_BITS + 10 - RSH;
  localparam int OS_W   = SAMPLE_BITS + 11;

  logic signed [SAMPLE_BITS-1:0] left_r, right_r;
  logic signed [X_W-1:0]         x_r, x_nxt;
  logic signed [31:0]            smoothed_r, low1_r, low2_r, high_r;
  logic signed [31:0]            prev_band_r, env_r, carry_r, y_r;
  logic                          sign_r;
  logic [32:0]                   mag_r;
  logic signed [31:0]            pole_r [SUB_POLE_COUNT];
  logic signed [P_W-1:0]         prod_r;
  logic signed [SUB_W-1:0]       sub_r, sub_nxt;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_r_r;

  logic [16:0]                   tgt;
  logic signed [SAMPLE_BITS:0]   mono_sum;
  logic signed [XS_W-1:0]        mono_scaled;
  logic signed [31:0]            y_sel;
  logic signed [A_W-1:0]         pin, op_a;
  logic signed [B_W-1:0]         op_b;
  logic [15:0]                   coef;
  logic                          use_pole;
  logic signed [P_W-1:0]         rnd16, mix_rnd;
  logic signed [63:0]            pole_sum, gain_val, band_diff;
  logic signed [31:0]            pole_upd, gain_upd, band_b;
  logic signed [32:0]            band_ext;
  logic [32:0]                   band_mag;
  logic signed [OS_W-1:0]        os_l, os_r;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [OS_W-1:0] v);
    logic [OS_W-SAMPLE_BITS:0]     hi;
    logic signed [SAMPLE_BITS-1:0] res;
    hi = v[OS_W-1:SAMPLE_BITS-1];
    if (&hi || ~|hi) begin
      res = v[SAMPLE_BITS-1:0];
    end else begin
      res = {v[OS_W-1], {(SAMPLE_BITS-1){~v[OS_W-1]}}};
    end
    return res;
  endfunction

  assign tgt = (cfg.target_amount > AMOUNT_ONE) ? AMOUNT_ONE : cfg.target_amount;
  assign status.bypass = (tgt == '0) && (smoothed_r <= BYPASS_LIMIT);

  // Mono sum scaled so that a full-scale sample is 1.0 in Q4.27.
  assign mono_sum    = (SAMPLE_BITS + 1)'(in_left_in) + (SAMPLE_BITS + 1)'(in_right_in);
  assign mono_scaled = XS_W'(mono_sum) <<< LSH;
  assign x_nxt       = X_W'(mono_scaled >>> (RSH + 1));

  // Operand selection for the shared multiplier.
  always_comb begin
    y_sel    = '0;
    pin      = '0;
    coef     = '0;
    use_pole = 1'b1;
    op_a     = '0;
    op_b     = '0;
    case (cmd.op)
      OP_AMOUNT: begin
        y_sel = smoothed_r;
        pin   = A_W'(tgt) <<< AMOUNT_SHIFT;
        coef  = cfg.amount_smooth_coef;
      end
      OP_LOW1: begin
        y_sel = low1_r;
        pin   = A_W'(x_r);
        coef  = cfg.band_lowpass_coef;
      end
      OP_LOW2: begin
        y_sel = low2_r;
        pin   = A_W'(low1_r);
        coef  = cfg.band_lowpass_coef;
      end
      OP_HIGH: begin
        y_sel = high_r;
        pin   = A_W'(low2_r);
        coef  = cfg.band_highpass_coef;
      end
      OP_ENV: begin
        y_sel = env_r;
        pin   = A_W'(mag_r);
        coef  = (pin > A_W'(env_r)) ? cfg.attack_coef : cfg.release_coef;
      end
      OP_SUB: begin
        // The pole chain rotates, so the pole being updated is always at the head.
        y_sel = pole_r[0];
        pin   = A_W'(carry_r);
        coef  = cfg.sub_lowpass_coef;
      end
      OP_GAIN: begin
        use_pole = 1'b0;
        op_a     = A_W'(env_r);
        op_b     = GAIN_2P2;
      end
      OP_MIX: begin
        use_pole = 1'b0;
        op_a     = A_W'(smoothed_r);
        op_b     = B_W'(pole_r[SUB_POLE_COUNT-1]);
      end
      default: use_pole = 1'b0;
    endcase
    if (use_pole) begin
      op_a = pin - A_W'(y_sel);
      op_b = B_W'({1'b0, coef});
    end
  end

  // Write-back arithmetic on the registered product.
  assign rnd16    = (prod_r + (P_W'(1) <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
  assign pole_sum = 64'(rnd16) + 64'(y_r);
  assign pole_upd = sat32(pole_sum);
  assign gain_val = sign_r ? -64'(rnd16) : 64'(rnd16);
  assign gain_upd = sat32(gain_val);
  assign mix_rnd  = (prod_r + (P_W'(1) <<< (MIX_SH - 1))) >>> MIX_SH;
  assign sub_nxt  = SUB_W'(mix_rnd);

  assign band_diff = 64'(low2_r) - 64'(high_r);
  assign band_b    = sat32(band_diff);
  assign band_ext  = 33'(band_b);
  assign band_mag  = (band_b < 0) ? 33'(-band_ext) : 33'(band_ext);

  assign os_l = OS_W'(left_r) + (OS_W'(sub_r) <<< RSH);
  assign os_r = OS_W'(right_r) + (OS_W'(sub_r) <<< RSH);

  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= in_left_in;
      right_r <= in_right_in;
      x_r     <= x_nxt;
      if (status.bypass) begin
        sub_r <= '0;
      end
    end
    if (cmd.mul) begin
      prod_r <= op_a * op_b;
      y_r    <= y_sel;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_GAIN: carry_r <= gain_upd;
        OP_SUB:  carry_r <= pole_upd;
        OP_MIX:  sub_r   <= sub_nxt;
        default: ;
      endcase
    end
    if (cmd.band) begin
      mag_r <= band_mag;
    end
    if (cmd.out_load) begin
      out_l_r <= sat_sample(os_l);
      out_r_r <= sat_sample(os_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r  <= '0;
      low1_r      <= '0;
      low2_r      <= '0;
      high_r      <= '0;
      prev_band_r <= '0;
      env_r       <= '0;
      sign_r      <= 1'b0;
      for (int i = 0; i < SUB_POLE_COUNT; i++) begin
        pole_r[i] <= '0;
      end
    end else begin
      if (cmd.load && status.bypass) begin
        smoothed_r <= '0;
      end
      if (cmd.band) begin
        // The octave sign flips on each rising zero crossing of the band.
        if (prev_band_r <= 0 && band_b > 0) begin
          sign_r <= ~sign_r;
        end
        prev_band_r <= band_b;
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_AMOUNT: smoothed_r <= pole_upd;
          OP_LOW1:   low1_r     <= pole_upd;
          OP_LOW2:   low2_r     <= pole_upd;
          OP_HIGH:   high_r     <= pole_upd;
          OP_ENV:    env_r      <= pole_upd;
          OP_SUB: begin
            for (int i = 0; i < SUB_POLE_COUNT - 1; i++) begin
              pole_r[i] <= pole_r[i+1];
            end
            pole_r[SUB_POLE_COUNT-1] <= pole_upd;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
